### sv/lgs_pkg.sv
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared constants and request types for the linear gradient scanline block.
// ----------------------------------------------------------------------------
package lgs_pkg;

    localparam int MAX_STOPS = 16;
    localparam int MAX_WIDTH = 4096;

    localparam int STOP_AW  = $clog2(MAX_STOPS);
    localparam int POS_W    = 13;
    localparam int COLOR_W  = 32;
    localparam int CNT_W    = 5;
    localparam int CFG_IW   = 2;
    localparam int CFG_DW   = 13;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    localparam logic [CFG_IW-1:0] CFG_LINE_WIDTH  = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_STOP_COUNT  = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_REPEAT_MODE = 2'd2;

    typedef struct packed {
        logic               opcode;
        logic [3:0]         stop_index;
        logic [POS_W-1:0]   stop_position;
        logic [COLOR_W-1:0] stop_color;
    } t_in_req;

    typedef struct packed {
        logic [7:0] pixel_red;
        logic [7:0] pixel_green;
        logic [7:0] pixel_blue;
        logic [7:0] pixel_alpha;
        logic       last_pixel;
    } t_out_req;

    typedef struct packed {
        logic [POS_W-1:0]   pos;
        logic [COLOR_W-1:0] color;
    } t_stop;

endpackage

### sv/lgs_stop_ram.sv
// ----------------------------------------------------------------------------
// lgs_stop_ram
// Color stop table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lgs_stop_ram
    import lgs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [STOP_AW-1:0] i_waddr,
    input  t_stop              i_wdata,
    input  logic [STOP_AW-1:0] i_raddr,
    output t_stop              o_rdata
);

    t_stop r_mem [MAX_STOPS];
    t_stop r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/lgs_div.sv
// ----------------------------------------------------------------------------
// lgs_div
// Restoring divider, 8-bit dividend by 13-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module lgs_div
    import lgs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [7:0]       i_dividend,
    input  logic [POS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [7:0]       o_quot,
    output logic [POS_W-1:0] o_rem
);

    logic             r_busy;
    logic             r_done;
    logic [2:0]       r_cnt;
    logic [7:0]       r_dvd;
    logic [POS_W-1:0] r_rem;
    logic [POS_W-1:0] r_div;
    logic [POS_W:0]   w_sh;
    logic             w_ge;
    logic [POS_W:0]   w_sub;

    assign w_sh  = {r_rem, r_dvd[7]};
    assign w_ge  = (w_sh >= {1'b0, r_div});
    assign w_sub = w_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[6:0], w_ge};
            r_rem <= w_ge ? w_sub[POS_W-1:0] : w_sh[POS_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dvd;
    assign o_rem  = r_rem;

endmodule

### sv/linear_gradient_scanline.sv
// Sequencing: a stop write goes straight into the stop table; a pixel inside a segment goes from S_IDLE to S_EMIT.
// A pixel that opens a segment first reads the table (S_RD0, S_RDN, S_LT), then examines stop pairs
// (S_TRY, S_RB, S_RC, S_EVAL), runs the divider once per channel and commits in S_SKIP before S_EMIT.
// One request at a time: the input stalls until the current pixel request is done.
// Reset (synchronous, active low) clears the walk, the counters and the registers to
// line_width 1, stop_count 2, no repeat; the stop table keeps its contents.
// ----------------------------------------------------------------------------
// linear_gradient_scanline
// RGBA gradient scanline generator with stop table and per-channel DDA.
// ----------------------------------------------------------------------------
module linear_gradient_scanline
    import lgs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_req           i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_req          o_out_req,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_RD0, S_RDN, S_LT, S_TRY, S_RB, S_RC, S_EVAL,
        S_DSTART, S_DWAIT, S_SKIP, S_EMIT
    } t_state;

    typedef enum logic [1:0] {OV_NONE, OV_ZERO, OV_WIDTH} t_ovr;

    typedef struct packed {
        logic [STOP_AW-1:0] addr;
        t_ovr               ovr;
    } t_vmap;

    typedef struct packed {
        logic [7:0]  val;
        logic [13:0] err;
    } t_dda;

    function automatic t_vmap vmap(input logic [4:0] k, input logic lead,
                                   input logic [CNT_W-1:0] n);
        t_vmap      m;
        logic [4:0] kk;
        kk = k - {4'd0, lead};
        if (lead && (k == 5'd0)) begin
            m.addr = '0;
            m.ovr  = OV_ZERO;
        end else if (kk < n) begin
            m.addr = kk[STOP_AW-1:0];
            m.ovr  = OV_NONE;
        end else begin
            m.addr = STOP_AW'(n - 5'd1);
            m.ovr  = OV_WIDTH;
        end
        return m;
    endfunction

    function automatic t_dda dda(input logic [7:0] val, input logic [13:0] err,
                                 input logic [8:0] quo, input logic [POS_W-1:0] rem,
                                 input logic sgn, input logic [POS_W-1:0] len);
        t_dda  d;
        d.val = val + quo[7:0];
        d.err = err - {1'b0, rem};
        if (d.err[13]) begin
            d.val = sgn ? d.val - 8'd1 : d.val + 8'd1;
            d.err = d.err + {1'b0, len};
        end
        return d;
    endfunction

    t_state r_state;

    logic [POS_W-1:0] r_line_width;
    logic [CNT_W-1:0] r_stop_count;
    logic             r_repeat;

    logic [POS_W-1:0] r_pe;
    logic [4:0]       r_seg;
    logic [4:0]       r_try;
    logic [POS_W-1:0] r_seg_rem;
    logic [POS_W-1:0] r_len;
    logic [7:0]       r_val [4];
    logic [13:0]      r_err [4];
    logic [8:0]       r_quo [4];
    logic [POS_W-1:0] r_rem [4];
    logic             r_sgn [4];

    logic             r_lead;
    logic [4:0]       r_m;
    logic [POS_W-1:0] r_pos0;
    t_vmap            r_v0;
    t_vmap            r_v1;
    logic [POS_W-1:0] r_p0;
    logic [POS_W-1:0] r_p1;
    logic [31:0]      r_c0;
    logic [31:0]      r_c1;
    logic [1:0]       r_ch;

    logic             r_out_valid;
    t_out_req         r_out;

    logic [POS_W-1:0]   w_w;
    logic [CNT_W-1:0]   w_n;
    logic               w_acc;
    logic               w_we;
    logic [STOP_AW-1:0] w_raddr;
    t_stop              w_rdata;
    t_stop              w_wdata;
    logic [4:0]         w_j;
    logic               w_fail;
    t_vmap              w_m0;
    t_vmap              w_m1;
    logic [POS_W-1:0]   w_rpos;
    logic [13:0]        w_diff;
    logic [7:0]         w_ys;
    logic [7:0]         w_ye;
    logic [7:0]         w_absd;
    logic               w_dstart;
    logic               w_ddone;
    logic [7:0]         w_dq;
    logic [POS_W-1:0]   w_dr;
    logic               w_oslot;
    logic [POS_W-1:0]   w_pe_acc;
    logic [POS_W-1:0]   w_pe_inc;
    t_dda               w_step [4];

    always_comb begin
        w_w = r_line_width;
        if (r_line_width == '0) begin
            w_w = POS_W'(1);
        end else if (r_line_width > POS_W'(MAX_WIDTH)) begin
            w_w = POS_W'(MAX_WIDTH);
        end
        w_n = r_stop_count;
        if (r_stop_count < CNT_W'(2)) begin
            w_n = CNT_W'(2);
        end else if (r_stop_count > CNT_W'(MAX_STOPS)) begin
            w_n = CNT_W'(MAX_STOPS);
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_we       = w_acc && (i_in_req.opcode == OP_WRITE)
                        && ({1'b0, i_in_req.stop_index} < 5'(MAX_STOPS));
    assign w_wdata    = '{pos: i_in_req.stop_position, color: i_in_req.stop_color};

    always_comb begin
        w_j    = r_seg + 5'd1;
        w_fail = (r_try + 5'd1 >= r_m);
        if (w_j > r_m - 5'd1) begin
            if (!r_repeat) begin
                w_fail = 1'b1;
            end
            w_j = 5'd1;
        end
        w_m0 = vmap(w_j - 5'd1, r_lead, w_n);
        w_m1 = vmap(w_j, r_lead, w_n);
    end

    always_comb begin
        unique case (r_state)
            S_RD0:   w_raddr = '0;
            S_RDN:   w_raddr = STOP_AW'(w_n - 5'd1);
            S_TRY:   w_raddr = w_m0.addr;
            S_RB:    w_raddr = r_v1.addr;
            default: w_raddr = '0;
        endcase
    end

    lgs_stop_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_in_req.stop_index[STOP_AW-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        unique case (r_state == S_RB ? r_v0.ovr : r_v1.ovr)
            OV_ZERO:  w_rpos = '0;
            OV_WIDTH: w_rpos = w_w;
            default:  w_rpos = w_rdata.pos;
        endcase
    end

    assign w_diff   = {1'b0, r_p1} - {1'b0, r_p0};
    assign w_ys     = r_c0[8*r_ch +: 8];
    assign w_ye     = r_c1[8*r_ch +: 8];
    assign w_absd   = (w_ys > w_ye) ? w_ys - w_ye : w_ye - w_ys;
    assign w_dstart = (r_state == S_DSTART);

    lgs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_dstart),
        .i_dividend (w_absd),
        .i_divisor  (r_len),
        .o_done     (w_ddone),
        .o_quot     (w_dq),
        .o_rem      (w_dr)
    );

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            w_step[c] = dda(r_val[c], r_err[c], r_quo[c], r_rem[c], r_sgn[c], r_len);
        end
    end

    assign w_oslot  = !r_out_valid || !i_out_stall;
    assign w_pe_acc = (r_pe >= w_w) ? '0 : r_pe;
    assign w_pe_inc = r_pe + POS_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_line_width <= POS_W'(1);
            r_stop_count <= CNT_W'(2);
            r_repeat     <= 1'b0;
            r_pe         <= '0;
            r_seg        <= '0;
            r_try        <= '0;
            r_seg_rem    <= '0;
            r_len        <= '0;
            r_out_valid  <= 1'b0;
            r_ch         <= '0;
            for (int c = 0; c < 4; c++) begin
                r_val[c] <= '0;
                r_err[c] <= '0;
                r_quo[c] <= '0;
                r_rem[c] <= '0;
                r_sgn[c] <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_LINE_WIDTH:  r_line_width <= i_cfg_data;
                    CFG_STOP_COUNT:  r_stop_count <= i_cfg_data[CNT_W-1:0];
                    CFG_REPEAT_MODE: r_repeat     <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if ((r_state == S_EMIT) && w_oslot) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc && (i_in_req.opcode == OP_PIXEL)) begin
                        r_pe <= w_pe_acc;
                        if (w_pe_acc == '0) begin
                            r_seg     <= '0;
                            r_seg_rem <= '0;
                            r_len     <= '0;
                            for (int c = 0; c < 4; c++) begin
                                r_val[c] <= '0;
                                r_err[c] <= '0;
                                r_quo[c] <= '0;
                                r_rem[c] <= '0;
                                r_sgn[c] <= 1'b0;
                            end
                            r_state <= S_RD0;
                        end else begin
                            r_state <= (r_seg_rem == '0) ? S_RD0 : S_EMIT;
                        end
                    end
                end
                S_RD0: r_state <= S_RDN;
                S_RDN: begin
                    r_pos0  <= w_rdata.pos;
                    r_state <= S_LT;
                end
                S_LT: begin
                    r_lead  <= !r_repeat && (r_pos0 != '0);
                    r_m     <= w_n + {4'd0, !r_repeat && (r_pos0 != '0)}
                               + {4'd0, !r_repeat && (w_rdata.pos < w_w)};
                    r_try   <= '0;
                    r_state <= S_TRY;
                end
                S_TRY: begin
                    if (w_fail) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_seg   <= w_j;
                        r_v0    <= w_m0;
                        r_v1    <= w_m1;
                        r_state <= S_RB;
                    end
                end
                S_RB: begin
                    r_p0    <= w_rpos;
                    r_c0    <= w_rdata.color;
                    r_state <= S_RC;
                end
                S_RC: begin
                    r_p1    <= w_rpos;
                    r_c1    <= w_rdata.color;
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    if (!w_diff[13] && (w_diff != '0)) begin
                        if (r_c0 == '0) begin
                            r_c0 <= {8'd0, r_c1[23:0]};
                        end else if (r_c1 == '0) begin
                            r_c1 <= {8'd0, r_c0[23:0]};
                        end
                        r_len     <= w_diff[POS_W-1:0];
                        r_seg_rem <= w_diff[POS_W-1:0];
                        r_ch      <= '0;
                        r_state   <= S_DSTART;
                    end else begin
                        r_try   <= r_try + 5'd1;
                        r_state <= S_TRY;
                    end
                end
                S_DSTART: r_state <= S_DWAIT;
                S_DWAIT: begin
                    if (w_ddone) begin
                        r_val[r_ch] <= w_ys;
                        r_err[r_ch] <= {2'b00, r_len[POS_W-1:1]};
                        r_quo[r_ch] <= (w_ys > w_ye) ? 9'd0 - {1'b0, w_dq} : {1'b0, w_dq};
                        r_rem[r_ch] <= w_dr;
                        r_sgn[r_ch] <= (w_ys >= w_ye);
                        r_ch        <= r_ch + 2'd1;
                        r_state     <= (r_ch == 2'd3) ? S_SKIP : S_DSTART;
                    end
                end
                S_SKIP: begin
                    if (r_pe != '0) begin
                        for (int c = 0; c < 4; c++) begin
                            r_val[c] <= w_step[c].val;
                            r_err[c] <= w_step[c].err;
                        end
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_oslot) begin
                        r_out.pixel_red   <= r_val[0];
                        r_out.pixel_green <= r_val[1];
                        r_out.pixel_blue  <= r_val[2];
                        r_out.pixel_alpha <= r_val[3];
                        r_out.last_pixel  <= (r_pe == w_w - POS_W'(1));
                        if (r_seg_rem != '0) begin
                            r_seg_rem <= r_seg_rem - POS_W'(1);
                            if (r_seg_rem != POS_W'(1)) begin
                                for (int c = 0; c < 4; c++) begin
                                    r_val[c] <= w_step[c].val;
                                    r_err[c] <= w_step[c].err;
                                end
                            end
                        end
                        r_pe    <= (w_pe_inc >= w_w) ? '0 : w_pe_inc;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

endmodule

### sv/lgs_checker.sv
// ----------------------------------------------------------------------------
// lgs_checker
// Port-level checks for the gradient scanline block.
// ----------------------------------------------------------------------------
module lgs_checker
    import lgs_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input t_in_req           i_in_req,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input t_out_req          o_out_req
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_req))
        else $error("stalled pixel request changed");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

    a_pixel_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_req.opcode == OP_PIXEL) |=> o_in_stall)
        else $error("pixel request did not occupy the block");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("pixel produced without a pending request");

endmodule

bind linear_gradient_scanline lgs_checker u_lgs_checker (.*);
